// ===== hw/rtl/ipc_pkg.sv =====
// ipc_pkg: shared types and constants for the restricted partition counter
// no dependencies; used by integer_partition_count_mod and ipc_checker
`timescale 1ns / 1ps

package ipc_pkg;

    // input field width (max_parts and total)
    localparam int unsigned FIELD_W = 10;
    // result width
    localparam int unsigned COUNT_W = 30;
    // default row store size minus one
    localparam int unsigned MAX_TOTAL_DEF = 1023;

    // modulus, one bit wider than the count so a sum of two residues fits
    localparam logic [COUNT_W:0] PRIME_MOD = 31'd1000000007;

    // slave and master tdata widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UPDATE,
        ST_READ,
        ST_WAIT,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/integer_partition_count_mod.sv =====
// integer_partition_count_mod: top level of the restricted partition counter
// depends on ipc_pkg and ipc_ram
`timescale 1ns / 1ps

// Counts the partitions of total into parts no larger than max_parts, modulo
// 1000000007 (the same as partitions into at most max_parts parts). One beat
// in gives one beat out; the block takes one item at a time and s_tready is
// high only while idle. A part limit above total acts as total; total above
// MAX_TOTAL gives count 0 right away. With L = min(max_parts, total) and
// T = total, an item is accepted, the row store is cleared over 0..T with
// entry 0 seeded with one, the row updates run for i=1..L over j=i..T, the
// answer is read from entry T and then presented until taken. The single
// modular adder and the one write port of the row RAM retire one
// row[j] += row[j-i] update per cycle; a one-entry write forward covers the
// read-after-write case where row[j-i] is written in the same cycle as its
// read is issued.
module integer_partition_count_mod #(
    parameter int unsigned MAX_TOTAL = ipc_pkg::MAX_TOTAL_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side: [9:0] max_parts, [19:10] total, [23:20] zero
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [ipc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // master side: [29:0] count, [31:30] zero
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ipc_pkg::M_TDATA_W-1:0] o_m_tdata
);

    localparam int unsigned Depth = MAX_TOTAL + 1;
    localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned FW    = ipc_pkg::FIELD_W;
    localparam int unsigned CW    = ipc_pkg::COUNT_W;

    // sequencer state
    ipc_pkg::t_state r_state, n_state;

    // item registers
    logic [FW-1:0] r_limit, n_limit;   // effective part limit
    logic [FW-1:0] r_goal,  n_goal;    // total
    logic [FW-1:0] r_i,     n_i;       // current part size
    logic [FW-1:0] r_j,     n_j;       // current row index
    logic [CW-1:0] r_count, n_count;

    // update pipeline: read issued last cycle, write this cycle
    logic          r_pend;
    logic [AW-1:0] r_rd_addr_a, r_rd_addr_b;

    // last write, for forwarding into the cycle after it
    logic          r_wr_vld;
    logic [AW-1:0] r_wr_addr;
    logic [CW-1:0] r_wr_data;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr_a, ram_raddr_b;
    logic [CW-1:0] ram_rdata_a, ram_rdata_b;

    // input fields
    logic [FW-1:0] in_max_parts;
    logic [FW-1:0] in_total;
    logic          in_accept;
    logic          in_too_big;

    assign in_max_parts = i_s_tdata[FW-1:0];
    assign in_total     = i_s_tdata[2*FW-1:FW];
    assign in_accept    = i_s_tvalid && o_s_tready;
    assign in_too_big   = (32'(in_total) > MAX_TOTAL);

    // row indexes to ram addresses; checked against MAX_TOTAL beforehand
    logic [FW-1:0]    j_minus_i;
    logic [FW+AW-1:0] ext_j, ext_jmi, ext_goal;

    assign j_minus_i = r_j - r_i;
    assign ext_j     = {{AW{1'b0}}, r_j};
    assign ext_jmi   = {{AW{1'b0}}, j_minus_i};
    assign ext_goal  = {{AW{1'b0}}, r_goal};

    // forwarded read data
    logic [CW-1:0] data_a, data_b;

    assign data_a = (r_wr_vld && (r_wr_addr == r_rd_addr_a)) ? r_wr_data : ram_rdata_a;
    assign data_b = (r_wr_vld && (r_wr_addr == r_rd_addr_b)) ? r_wr_data : ram_rdata_b;

    // modular add: both operands below the prime
    logic [CW:0] sum_raw, sum_sub;
    logic [CW-1:0] sum_mod;

    assign sum_raw = {1'b0, data_a} + {1'b0, data_b};
    assign sum_sub = sum_raw - ipc_pkg::PRIME_MOD;
    assign sum_mod = (sum_raw >= ipc_pkg::PRIME_MOD) ? sum_sub[CW-1:0] : sum_raw[CW-1:0];

    logic j_at_goal;
    assign j_at_goal = (r_j == r_goal);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = in_too_big ? ipc_pkg::ST_OUT : ipc_pkg::ST_CLEAR;
                end
            end
            ipc_pkg::ST_CLEAR: begin
                if (j_at_goal) begin
                    n_state = (r_limit == '0) ? ipc_pkg::ST_READ : ipc_pkg::ST_UPDATE;
                end
            end
            ipc_pkg::ST_UPDATE: begin
                if (j_at_goal && (r_i == r_limit)) begin
                    n_state = ipc_pkg::ST_READ;
                end
            end
            ipc_pkg::ST_READ: n_state = ipc_pkg::ST_WAIT;
            ipc_pkg::ST_WAIT: n_state = ipc_pkg::ST_OUT;
            ipc_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_state = ipc_pkg::ST_IDLE;
                end
            end
            default: n_state = ipc_pkg::ST_IDLE;
        endcase
    end

    // outputs and ram control
    always_comb begin
        o_s_tready  = 1'b0;
        o_m_tvalid  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_rd_addr_a;
        ram_wdata   = sum_mod;
        ram_raddr_a = ext_j[AW-1:0];
        ram_raddr_b = ext_jmi[AW-1:0];
        // finishing update from the previous cycle
        if (r_pend) begin
            ram_we = 1'b1;
        end
        unique case (r_state)
            ipc_pkg::ST_IDLE: o_s_tready = 1'b1;
            ipc_pkg::ST_CLEAR: begin
                // zero the row, entry 0 seeded with one
                ram_we    = 1'b1;
                ram_waddr = ext_j[AW-1:0];
                ram_wdata = (r_j == '0) ? CW'(1) : '0;
            end
            ipc_pkg::ST_UPDATE: ;
            ipc_pkg::ST_READ: begin
                ram_raddr_a = ext_goal[AW-1:0];
                ram_raddr_b = ext_goal[AW-1:0];
            end
            ipc_pkg::ST_WAIT: ;
            ipc_pkg::ST_OUT: o_m_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign o_m_tdata = {{(ipc_pkg::M_TDATA_W - CW){1'b0}}, r_count};

    // counters and item registers
    always_comb begin
        n_limit = r_limit;
        n_goal  = r_goal;
        n_i     = r_i;
        n_j     = r_j;
        n_count = r_count;
        unique case (r_state)
            ipc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_goal  = in_total;
                    n_limit = (in_max_parts > in_total) ? in_total : in_max_parts;
                    n_i     = '0;
                    n_j     = '0;
                    n_count = '0;
                end
            end
            ipc_pkg::ST_CLEAR: begin
                if (j_at_goal) begin
                    n_i = FW'(1);
                    n_j = FW'(1);
                end else begin
                    n_j = r_j + FW'(1);
                end
            end
            ipc_pkg::ST_UPDATE: begin
                // next part size starts at j = i + 1
                if (j_at_goal) begin
                    n_i = r_i + FW'(1);
                    n_j = r_i + FW'(1);
                end else begin
                    n_j = r_j + FW'(1);
                end
            end
            ipc_pkg::ST_READ: ;
            ipc_pkg::ST_WAIT: n_count = data_a;
            ipc_pkg::ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ipc_pkg::ST_IDLE;
            r_pend   <= 1'b0;
            r_wr_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= (r_state == ipc_pkg::ST_UPDATE);
            r_wr_vld <= ram_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit     <= n_limit;
        r_goal      <= n_goal;
        r_i         <= n_i;
        r_j         <= n_j;
        r_count     <= n_count;
        r_rd_addr_a <= ram_raddr_a;
        r_rd_addr_b <= ram_raddr_b;
        r_wr_addr   <= ram_waddr;
        r_wr_data   <= ram_wdata;
    end

    // row store
    ipc_ram #(
        .WIDTH (CW),
        .DEPTH (Depth)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

endmodule

// ===== hw/rtl/ipc_ram.sv =====
// ipc_ram: generic single-write, dual-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module ipc_ram #(
    parameter  int unsigned WIDTH = 30,
    parameter  int unsigned DEPTH = 1024,
    localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr_a,
    input  logic [AddrW-1:0] i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== hw/rtl/ipc_checker.sv =====
// ipc_checker: port-level assertions for integer_partition_count_mod
// depends on ipc_pkg; bound to the top level below
`timescale 1ns / 1ps

module ipc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [ipc_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [ipc_pkg::M_TDATA_W-1:0] o_m_tdata
);

    // one item at a time: never ready for input while a result is offered
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while result pending");

    // an accepted beat takes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready right after accept");

    // once the result is taken the block is idle again
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready) |=> (o_s_tready && !o_m_tvalid))
        else $error("not idle after result beat");

    // result is a reduced residue with zero padding
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({1'b0, o_m_tdata[ipc_pkg::COUNT_W-1:0]} < ipc_pkg::PRIME_MOD)
            && (o_m_tdata[ipc_pkg::M_TDATA_W-1:ipc_pkg::COUNT_W] == '0))
        else $error("count out of range");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

endmodule

bind integer_partition_count_mod ipc_checker u_ipc_checker (.*);
